// ===== rtl/frb_pkg.sv =====
// ----------------------------------------------------------------------------
// frb_pkg
// shared types, constants and the crc step for the framed byte receiver
// ----------------------------------------------------------------------------
package frb_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 7;
    localparam int IDX_W      = 6;
    localparam int CRC_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 2'd2;

    localparam logic                 MODE_RESET   = 1'b1;
    localparam logic [BYTE_W-1:0]    HEADER_RESET = 8'd170;
    localparam logic [LEN_W-1:0]     MAXLEN_RESET = 7'd32;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic absorb;
        logic ld_src;
        logic ld_dst;
        logic ld_func;
        logic ld_len_lo;
        logic ld_len;
        logic wr_payload;
        logic ld_chk1;
        logic clr_idx;
        logic inc_idx;
        logic ld_out;
    } frb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hdr_match;
        logic len_ok;
        logic len_zero;
        logic data_done;
        logic check_good;
        logic idx_last;
        logic out_free;
    } frb_status_t;

    // one byte of crc-16/ccitt-false, msb first
    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/frb_if.sv =====
// ----------------------------------------------------------------------------
// frb_byte_if / frb_result_if
// valid/ready channels for received bytes and frame results
// ----------------------------------------------------------------------------
interface frb_byte_if
    import frb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface frb_result_if
    import frb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] src_addr;
    logic [BYTE_W-1:0] dst_addr;
    logic [BYTE_W-1:0] func_code;
    logic [LEN_W-1:0]  payload_len;
    logic [BYTE_W-1:0] payload_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              last;

    modport source (output valid, output src_addr, output dst_addr, output func_code,
                    output payload_len, output payload_byte, output byte_index,
                    output last, input ready);
    modport sink   (input valid, input src_addr, input dst_addr, input func_code,
                    input payload_len, input payload_byte, input byte_index,
                    input last, output ready);
endinterface

// ===== rtl/frb_ram.sv =====
// ----------------------------------------------------------------------------
// frb_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module frb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/frb_dp.sv =====
// ----------------------------------------------------------------------------
// frb_dp
// frame fields, checksums, payload store and result register
// ----------------------------------------------------------------------------
module frb_dp
    import frb_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [BYTE_W-1:0]     rx_byte,
    input  frb_cmd_t              cmd,
    output frb_status_t           status,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [BYTE_W-1:0]     src_addr,
    output logic [BYTE_W-1:0]     dst_addr,
    output logic [BYTE_W-1:0]     func_code,
    output logic [LEN_W-1:0]      payload_len,
    output logic [BYTE_W-1:0]     payload_byte,
    output logic [IDX_W-1:0]      byte_index,
    output logic                  last
);

    localparam int AW = MAX_PAYLOAD > 1 ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    logic              mode_reg;
    logic [BYTE_W-1:0] header_reg;
    logic [LEN_W-1:0]  max_len_reg;

    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] sos_reg, sos_next;
    logic [BYTE_W-1:0] src_reg, dst_reg, func_reg, len_lo_reg, chk1_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [AW-1:0]     idx_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] ram_rdata;
    logic [LEN_W-1:0]  limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_RESET;
            header_reg  <= HEADER_RESET;
            max_len_reg <= MAXLEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHECKSUM_MODE: mode_reg    <= cfg_data[0];
                CFG_HEADER_BYTE:   header_reg  <= cfg_data;
                CFG_MAX_LENGTH:    max_len_reg <= cfg_data[LEN_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        crc_next = crc_step(crc_reg, rx_byte);
        sum_next = sum_reg + rx_byte;
        sos_next = sos_reg + sum_next;
    end

    assign count_next = count_reg + LEN_W'(1);
    assign limit      = (max_len_reg > MAX_LEN) ? MAX_LEN : max_len_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            crc_reg <= crc_step(CRC_INIT, rx_byte);
            sum_reg <= rx_byte;
            sos_reg <= rx_byte;
        end
        else if (cmd.absorb)
        begin
            crc_reg <= crc_next;
            sum_reg <= sum_next;
            sos_reg <= sos_next;
        end
        if (cmd.ld_src)    src_reg    <= rx_byte;
        if (cmd.ld_dst)    dst_reg    <= rx_byte;
        if (cmd.ld_func)   func_reg   <= rx_byte;
        if (cmd.ld_len_lo) len_lo_reg <= rx_byte;
        if (cmd.ld_chk1)   chk1_reg   <= rx_byte;
        if (cmd.ld_len)
        begin
            len_reg   <= len_lo_reg[LEN_W-1:0];
            count_reg <= '0;
        end
        else if (cmd.wr_payload)
            count_reg <= count_next;
        if (cmd.clr_idx)
            idx_reg <= '0;
        else if (cmd.inc_idx)
            idx_reg <= idx_reg + AW'(1);
    end

    frb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .clk   (clk),
        .we    (cmd.wr_payload),
        .waddr (count_reg[AW-1:0]),
        .wdata (rx_byte),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        status.hdr_match = (rx_byte == header_reg);
        status.len_ok    = (rx_byte == '0) && (len_lo_reg <= BYTE_W'(limit));
        status.len_zero  = (len_lo_reg == '0);
        status.data_done = (count_next >= len_reg);
        if (mode_reg)
            status.check_good = ({chk1_reg, rx_byte} == crc_reg);
        else
            status.check_good = (chk1_reg == sum_reg) && (rx_byte == sos_reg);
        status.idx_last  = (len_reg == '0) || (LEN_W'(idx_reg) == len_reg - LEN_W'(1));
        status.out_free  = !out_valid_reg || out_ready;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.ld_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_out)
        begin
            src_addr     <= src_reg;
            dst_addr     <= dst_reg;
            func_code    <= func_reg;
            payload_len  <= len_reg;
            payload_byte <= (len_reg == '0) ? '0 : ram_rdata;
            byte_index   <= IDX_W'(idx_reg);
            last         <= status.idx_last;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_out |-> (!out_valid_reg || out_ready))
        else $error("result register loaded while a result is pending");
    a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_payload |-> (count_reg < MAX_LEN))
        else $error("payload write beyond store depth");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.inc_idx |-> (LEN_W'(idx_reg) + LEN_W'(1) < len_reg))
        else $error("drain index stepped past the frame length");
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_out |=> out_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

// ===== rtl/frb_ctrl.sv =====
// ----------------------------------------------------------------------------
// frb_ctrl
// frame parse and result drain state machine
// ----------------------------------------------------------------------------
module frb_ctrl
    import frb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  frb_status_t status,
    output frb_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_HUNT,
        S_SRC,
        S_DST,
        S_FUNC,
        S_LENLO,
        S_LENHI,
        S_DATA,
        S_CHK1,
        S_CHK2,
        S_DRAIN_RD,
        S_DRAIN_LD
    } state_t;

    state_t state_reg, state_next;
    logic   in_fire;

    assign in_ready = (state_reg != S_DRAIN_RD) && (state_reg != S_DRAIN_LD);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_HUNT:
                if (in_fire && status.hdr_match)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SRC;
                end
            S_SRC:
                if (in_fire)
                begin
                    cmd.ld_src = 1'b1;
                    cmd.absorb = 1'b1;
                    state_next = S_DST;
                end
            S_DST:
                if (in_fire)
                begin
                    cmd.ld_dst = 1'b1;
                    cmd.absorb = 1'b1;
                    state_next = S_FUNC;
                end
            S_FUNC:
                if (in_fire)
                begin
                    cmd.ld_func = 1'b1;
                    cmd.absorb  = 1'b1;
                    state_next  = S_LENLO;
                end
            S_LENLO:
                if (in_fire)
                begin
                    cmd.ld_len_lo = 1'b1;
                    cmd.absorb    = 1'b1;
                    state_next    = S_LENHI;
                end
            S_LENHI:
                if (in_fire)
                begin
                    cmd.ld_len = 1'b1;
                    cmd.absorb = 1'b1;
                    priority if (!status.len_ok)
                        state_next = S_HUNT;
                    else if (status.len_zero)
                        state_next = S_CHK1;
                    else
                        state_next = S_DATA;
                end
            S_DATA:
                if (in_fire)
                begin
                    cmd.wr_payload = 1'b1;
                    cmd.absorb     = 1'b1;
                    if (status.data_done)
                        state_next = S_CHK1;
                end
            S_CHK1:
                if (in_fire)
                begin
                    cmd.ld_chk1 = 1'b1;
                    state_next  = S_CHK2;
                end
            S_CHK2:
                if (in_fire)
                begin
                    if (status.check_good)
                    begin
                        cmd.clr_idx = 1'b1;
                        state_next  = S_DRAIN_RD;
                    end
                    else
                        state_next = S_HUNT;
                end
            S_DRAIN_RD:
                state_next = S_DRAIN_LD;
            S_DRAIN_LD:
                if (status.out_free)
                begin
                    cmd.ld_out = 1'b1;
                    if (status.idx_last)
                        state_next = S_HUNT;
                    else
                    begin
                        cmd.inc_idx = 1'b1;
                        state_next  = S_DRAIN_RD;
                    end
                end
            default:
                state_next = S_HUNT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_HUNT;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN_RD) |=> (state_reg == S_DRAIN_LD))
        else $error("drain read not followed by load");
    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN_LD && status.out_free && status.idx_last)
            |=> (state_reg == S_HUNT))
        else $error("drain did not end on the last result");
    a_good_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK2 && in_fire && status.check_good) |=> !in_ready)
        else $error("input taken while draining a good frame");
`endif

endmodule

// ===== rtl/framed_byte_receiver.sv =====
// ----------------------------------------------------------------------------
// framed_byte_receiver
// header hunt, frame parse with crc or sum check, payload result drain
// ----------------------------------------------------------------------------
// parsing: one byte per cycle; after the second check byte of a good
//   frame the payload drains one result per byte (one for an empty
//   payload), each by a store read, then a load into the result register
//   once it is free, with byte input held off until the drain ends
// reset: rst_n asynchronous, active low; back to header hunt, registers to
//   their defaults, no pending result; the payload store needs no clearing
// ----------------------------------------------------------------------------
module framed_byte_receiver
    import frb_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    frb_byte_if.sink              rx_ch,
    frb_result_if.source          res_ch
);

    // command and status between the state machine and the datapath
    frb_cmd_t    cmd;
    frb_status_t status;

    // the controller sequences bytes through the frame fields and, on a good
    // check, walks the stored payload out one item at a time
    frb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx_ch.valid),
        .in_ready (rx_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // the datapath keeps registers, running crc and sums, the payload store
    // and the result register that decouples the output side
    frb_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rx_byte      (rx_ch.rx_byte),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (res_ch.ready),
        .out_valid    (res_ch.valid),
        .src_addr     (res_ch.src_addr),
        .dst_addr     (res_ch.dst_addr),
        .func_code    (res_ch.func_code),
        .payload_len  (res_ch.payload_len),
        .payload_byte (res_ch.payload_byte),
        .byte_index   (res_ch.byte_index),
        .last         (res_ch.last)
    );

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the framed byte receiver: a byte feeder and a
// result checker built around a cycle-free predictor of the frame parser
// ----------------------------------------------------------------------------
// the stimulus is a queue of received bytes, register writes and idling
// changes, filled once at time zero; a short directed run at the reset
// settings comes first, then seven phases of mostly well-formed frames with
// random content, mixed with corrupted checks, checks of the other mode,
// lengths above the limit, cut-off frames and line noise; every accepted
// byte goes through the predictor, and every good frame queues one result
// per payload byte, or one if empty, for the checker to match on the result channel
// ----------------------------------------------------------------------------
module tb;
    import frb_pkg::*;

    localparam int                   PAYLOAD_DEPTH = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 2'd3;
    localparam int                   SETTLE_CYCLES = 8;
    localparam int                   TAIL_CYCLES   = 16;
    localparam int                   STALL_LIMIT   = 4000;
    localparam int                   PHASE_COUNT   = 7;
    localparam int                   PHASE_BYTES   = 24;
    localparam int                   PRINT_CAP     = 100;

    // parser position, mirrors the receiver's frame walk
    typedef enum logic [3:0] {
        RX_HUNT,
        RX_SRC,
        RX_DST,
        RX_FUNC,
        RX_LEN_LO,
        RX_LEN_HI,
        RX_DATA,
        RX_CHK1,
        RX_CHK2
    } rx_phase_t;

    typedef enum logic [1:0] {
        FEED_BYTE,
        FEED_REG,
        FEED_IDLING
    } feed_kind_t;

    typedef enum logic [1:0] {
        CHK_INTACT,
        CHK_BIT_FLIP,
        CHK_OTHER_MODE
    } check_flaw_t;

    typedef struct {
        feed_kind_t           kind;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [BYTE_W-1:0]    value;
        int                   send_idle;
        int                   recv_stall;
    } feed_entry_t;

    typedef struct packed {
        logic [BYTE_W-1:0] src_addr;
        logic [BYTE_W-1:0] dst_addr;
        logic [BYTE_W-1:0] func_code;
        logic [LEN_W-1:0]  payload_len;
        logic [BYTE_W-1:0] payload_byte;
        logic [IDX_W-1:0]  byte_index;
        logic              last;
    } frame_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    frb_byte_if   rx_ch ();
    frb_result_if res_ch ();

    // stimulus store and frame assembly scratch
    feed_entry_t       feed_q[$];
    logic [BYTE_W-1:0] frame_bytes[$];
    logic [BYTE_W-1:0] carry_bytes[$];
    int                fed_bytes = 0;
    logic              gen_mode  = MODE_RESET;
    logic [BYTE_W-1:0] gen_hdr   = HEADER_RESET;
    int                gen_lim   = MAXLEN_RESET;

    // predictor copy of the registers
    logic              mirror_mode = MODE_RESET;
    logic [BYTE_W-1:0] mirror_hdr  = HEADER_RESET;
    logic [LEN_W-1:0]  mirror_max  = MAXLEN_RESET;

    // predictor copy of the parse state
    rx_phase_t         rx_phase = RX_HUNT;
    logic [CRC_W-1:0]  crc_acc  = CRC_INIT;
    logic [BYTE_W-1:0] sum_acc  = '0;
    logic [BYTE_W-1:0] sum2_acc = '0;
    logic [BYTE_W-1:0] f_src    = '0;
    logic [BYTE_W-1:0] f_dst    = '0;
    logic [BYTE_W-1:0] f_func   = '0;
    logic [BYTE_W-1:0] f_chk1   = '0;
    logic [15:0]       f_len    = '0;
    logic [LEN_W-1:0]  f_count  = '0;
    logic [BYTE_W-1:0] payload_mem[PAYLOAD_DEPTH];

    // results of good frames still to come out
    frame_result_t due_results[$];

    bit byte_taken    = 1'b0;
    int quiet_cycles  = 0;
    int stall_cycles  = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int error_count   = 0;

    framed_byte_receiver #(
        .MAX_PAYLOAD (PAYLOAD_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_ch     (rx_ch),
        .res_ch    (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // checks and predictor
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // crc-16/ccitt-false, one data bit at a time, msb first
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] acc,
                                                    input logic [BYTE_W-1:0] d);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = acc;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            fb = c[CRC_W-1] ^ d[i];
            c  = c << 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // both checks always run, the mode only picks one at the end
    function automatic void fold_byte(input logic [BYTE_W-1:0] b);
        crc_acc  = crc16_byte(crc_acc, b);
        sum_acc  = sum_acc + b;
        sum2_acc = sum2_acc + sum_acc;
    endfunction

    function automatic void write_mirror_reg(input logic [CFG_IDX_W-1:0] idx,
                                             input logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_CHECKSUM_MODE: mirror_mode = d[0];
            CFG_HEADER_BYTE:   mirror_hdr  = d[BYTE_W-1:0];
            CFG_MAX_LENGTH:    mirror_max  = d[LEN_W-1:0];
            default:           ;
        endcase
    endfunction

    // advance the parse by one received byte, queue results of a good frame
    function automatic void parse_rx_byte(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] lim;
        logic             good;
        int               cnt;
        frame_result_t    r;
        lim = (mirror_max > PAYLOAD_DEPTH) ? LEN_W'(PAYLOAD_DEPTH) : mirror_max;
        case (rx_phase)
            RX_HUNT:
            begin
                if (b == mirror_hdr)
                begin
                    crc_acc  = crc16_byte(CRC_INIT, b);
                    sum_acc  = b;
                    sum2_acc = b;
                    rx_phase = RX_SRC;
                end
            end
            RX_SRC:
            begin
                f_src = b;
                fold_byte(b);
                rx_phase = RX_DST;
            end
            RX_DST:
            begin
                f_dst = b;
                fold_byte(b);
                rx_phase = RX_FUNC;
            end
            RX_FUNC:
            begin
                f_func = b;
                fold_byte(b);
                rx_phase = RX_LEN_LO;
            end
            RX_LEN_LO:
            begin
                f_len = {8'h00, b};
                fold_byte(b);
                rx_phase = RX_LEN_HI;
            end
            RX_LEN_HI:
            begin
                f_len[15:8] = b;
                fold_byte(b);
                f_count = '0;
                // an oversize length drops straight back to the hunt
                if (f_len > lim)
                    rx_phase = RX_HUNT;
                else if (f_len == 0)
                    rx_phase = RX_CHK1;
                else
                    rx_phase = RX_DATA;
            end
            RX_DATA:
            begin
                payload_mem[f_count[IDX_W-1:0]] = b;
                f_count = f_count + 1'b1;
                fold_byte(b);
                if (f_count >= f_len)
                    rx_phase = RX_CHK1;
            end
            RX_CHK1:
            begin
                f_chk1   = b;
                rx_phase = RX_CHK2;
            end
            RX_CHK2:
            begin
                if (mirror_mode)
                    good = ({f_chk1, b} == crc_acc);
                else
                    good = (f_chk1 == sum_acc) && (b == sum2_acc);
                if (good)
                begin
                    // an empty payload still gives one result
                    cnt = (f_len == 0) ? 1 : int'(f_len);
                    for (int k = 0; k < cnt; k++)
                    begin
                        r.src_addr     = f_src;
                        r.dst_addr     = f_dst;
                        r.func_code    = f_func;
                        r.payload_len  = f_len[LEN_W-1:0];
                        r.payload_byte = (f_len == 0) ? '0 : payload_mem[k];
                        r.byte_index   = IDX_W'(k);
                        r.last         = (k == cnt - 1);
                        due_results.push_back(r);
                    end
                end
                rx_phase = RX_HUNT;
            end
            default: rx_phase = RX_HUNT;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus construction
    // ------------------------------------------------------------------------

    function automatic void push_entry(input feed_kind_t kind,
                                       input logic [CFG_IDX_W-1:0] idx,
                                       input logic [BYTE_W-1:0] value,
                                       input int send_idle, input int recv_stall);
        feed_entry_t e;
        e.kind       = kind;
        e.reg_index  = idx;
        e.value      = value;
        e.send_idle  = send_idle;
        e.recv_stall = recv_stall;
        feed_q.push_back(e);
        if (kind == FEED_BYTE)
            fed_bytes++;
    endfunction

    function automatic void push_frame(input int n);
        for (int i = 0; i < n; i++)
            push_entry(FEED_BYTE, CFG_CHECKSUM_MODE, frame_bytes[i], 0, 0);
    endfunction

    // a byte that equals the header now and then, to test in-frame headers
    function automatic logic [BYTE_W-1:0] random_byte(input logic [BYTE_W-1:0] hdr,
                                                      input int hdr_pct);
        if ($urandom_range(0, 99) < hdr_pct)
            return hdr;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // mostly short payloads, sometimes anywhere up to the limit, now and
    // then exactly the limit
    function automatic int pick_length(input int lim);
        int r;
        r = $urandom_range(0, 19);
        if (lim == 0)
            return 0;
        if (r == 0)
            return lim;
        if (r < 3)
            return $urandom_range(0, lim);
        return $urandom_range(0, (lim < 6) ? lim : 6);
    endfunction

    // header, src, dst, func, length lo/hi, payload, two check bytes
    function automatic void assemble_frame(input logic [BYTE_W-1:0] hdr,
                                           input logic mode,
                                           input logic [BYTE_W-1:0] src,
                                           input logic [BYTE_W-1:0] dst,
                                           input logic [BYTE_W-1:0] func,
                                           input logic [15:0] len,
                                           input int hdr_pct,
                                           input check_flaw_t flaw);
        logic [CRC_W-1:0]  crc;
        logic [BYTE_W-1:0] s1;
        logic [BYTE_W-1:0] s2;
        logic [BYTE_W-1:0] c1;
        logic [BYTE_W-1:0] c2;
        int                n;
        frame_bytes = {};
        frame_bytes.push_back(hdr);
        frame_bytes.push_back(src);
        frame_bytes.push_back(dst);
        frame_bytes.push_back(func);
        frame_bytes.push_back(len[7:0]);
        frame_bytes.push_back(len[15:8]);
        n = (len > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : int'(len);
        for (int i = 0; i < n; i++)
            frame_bytes.push_back(random_byte(hdr, hdr_pct));
        crc = CRC_INIT;
        s1  = '0;
        s2  = '0;
        foreach (frame_bytes[i])
        begin
            crc = crc16_byte(crc, frame_bytes[i]);
            s1  = s1 + frame_bytes[i];
            s2  = s2 + s1;
        end
        if (mode ^ (flaw == CHK_OTHER_MODE))
            {c1, c2} = crc;
        else
            {c1, c2} = {s1, s2};
        if (flaw == CHK_BIT_FLIP)
            {c1, c2} = {c1, c2} ^ (16'h0001 << $urandom_range(0, 15));
        frame_bytes.push_back(c1);
        frame_bytes.push_back(c2);
    endfunction

    // one random sequence under the settings planned for the current phase
    function automatic void add_random_sequence();
        int                pick;
        int                n;
        logic [15:0]       len;
        logic [BYTE_W-1:0] nb;
        check_flaw_t       flaw;
        pick = $urandom_range(0, 99);
        if (pick < 84)
        begin
            // mostly good frames, some with a broken or foreign check
            flaw = (pick < 68) ? CHK_INTACT : ((pick < 78) ? CHK_BIT_FLIP : CHK_OTHER_MODE);
            len  = 16'(pick_length(gen_lim));
            assemble_frame(gen_hdr, gen_mode, random_byte(gen_hdr, 12),
                           random_byte(gen_hdr, 12), random_byte(gen_hdr, 12),
                           len, 12, flaw);
            push_frame(frame_bytes.size());
        end
        else if (pick < 91)
        begin
            // length above the limit, the frame ends after its length bytes
            if ($urandom_range(0, 1))
                len = 16'(gen_lim + 1 + $urandom_range(0, 3));
            else
                len = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
            assemble_frame(gen_hdr, gen_mode, random_byte(gen_hdr, 12),
                           random_byte(gen_hdr, 12), random_byte(gen_hdr, 12),
                           len, 0, CHK_INTACT);
            push_frame(6);
        end
        else if (pick < 95)
        begin
            // frame cut off somewhere before its last check byte
            assemble_frame(gen_hdr, gen_mode, random_byte(gen_hdr, 12),
                           random_byte(gen_hdr, 12), random_byte(gen_hdr, 12),
                           16'(pick_length(gen_lim)), 12, CHK_INTACT);
            push_frame($urandom_range(1, frame_bytes.size() - 1));
        end
        else
        begin
            // line noise, rarely a stray header
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
            begin
                nb = BYTE_W'($urandom_range(0, 255));
                if (nb == gen_hdr && $urandom_range(0, 3) != 0)
                    nb = ~nb;
                push_entry(FEED_BYTE, CFG_CHECKSUM_MODE, nb, 0, 0);
            end
        end
    endfunction

    // register settings and idling for each random phase; the extremes of
    // every register show up here, including a limit above the store depth
    // and a limit value with its unused top data bit set
    function automatic void phase_plan(input int p, output logic mode,
                                       output logic [BYTE_W-1:0] hdr,
                                       output logic [CFG_DATA_W-1:0] maxl,
                                       output int send_idle, output int recv_stall);
        case (p)
            0:       begin mode = 1'b0; hdr = 8'h00; maxl = 8'd0;   send_idle = 0;  recv_stall = 0;  end
            1:       begin mode = 1'b1; hdr = 8'hFF; maxl = 8'd64;  send_idle = 73; recv_stall = 0;  end
            2:       begin mode = 1'b0; hdr = 8'h55; maxl = 8'd127; send_idle = 0;  recv_stall = 73; end
            3:       begin mode = 1'b1; hdr = 8'h3C; maxl = 8'd5;   send_idle = 24; recv_stall = 24; end
            4:       begin mode = 1'b0; hdr = 8'hAA; maxl = 8'hA0;  send_idle = 0;  recv_stall = 0;  end
            5:       begin mode = 1'b1; hdr = 8'($urandom_range(0, 255)); maxl = 8'd16;
                           send_idle = 73; recv_stall = 0; end
            default: begin mode = 1'b0; hdr = 8'($urandom_range(0, 255)); maxl = 8'd64;
                           send_idle = 0; recv_stall = 73; end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // byte feeder, register writes and result back-pressure, all at negedge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : feed_driver
        feed_entry_t head;
        logic        next_valid;
        logic        next_we;
        if (rst_n)
        begin
            res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            // a byte on offer stays put until the receiver takes it
            if (!(rx_ch.valid && !byte_taken))
            begin
                next_valid = 1'b0;
                next_we    = 1'b0;
                if (feed_q.size() != 0)
                begin
                    head = feed_q[0];
                    case (head.kind)
                        FEED_IDLING:
                        begin
                            send_idle_pct = head.send_idle;
                            stall_pct     = head.recv_stall;
                            void'(feed_q.pop_front());
                        end
                        FEED_REG:
                        begin
                            // only once all due results are out and the
                            // receiver has had time to finish a dropped frame
                            if (due_results.size() == 0 && quiet_cycles >= SETTLE_CYCLES)
                            begin
                                next_we   = 1'b1;
                                cfg_index <= head.reg_index;
                                cfg_data  <= CFG_DATA_W'(head.value);
                                void'(feed_q.pop_front());
                            end
                        end
                        default:
                        begin
                            if ($urandom_range(0, 99) >= send_idle_pct)
                            begin
                                next_valid     = 1'b1;
                                rx_ch.rx_byte <= head.value;
                                void'(feed_q.pop_front());
                            end
                        end
                    endcase
                end
                rx_ch.valid <= next_valid;
                cfg_we      <= next_we;
            end
        end
    end

    // ------------------------------------------------------------------------
    // sample everything at posedge: register writes and accepted bytes feed
    // the predictor, accepted results are checked against the oldest due one
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_watch
        frame_result_t got;
        frame_result_t want;
        string         diffs;
        bit            res_taken;
        if (rst_n)
        begin
            byte_taken = rx_ch.valid && rx_ch.ready;
            res_taken  = res_ch.valid && res_ch.ready;
            if (cfg_we)
                write_mirror_reg(cfg_index, cfg_data);
            if (byte_taken)
                parse_rx_byte(rx_ch.rx_byte);
            if (res_taken)
            begin
                got.src_addr     = res_ch.src_addr;
                got.dst_addr     = res_ch.dst_addr;
                got.func_code    = res_ch.func_code;
                got.payload_len  = res_ch.payload_len;
                got.payload_byte = res_ch.payload_byte;
                got.byte_index   = res_ch.byte_index;
                got.last         = res_ch.last;
                if (due_results.size() == 0)
                    report_mismatch($sformatf("result %h with none due", got));
                else
                begin
                    want  = due_results.pop_front();
                    diffs = "";
                    if (got.src_addr !== want.src_addr)
                        diffs = {diffs, " src_addr"};
                    if (got.dst_addr !== want.dst_addr)
                        diffs = {diffs, " dst_addr"};
                    if (got.func_code !== want.func_code)
                        diffs = {diffs, " func_code"};
                    if (got.payload_len !== want.payload_len)
                        diffs = {diffs, " payload_len"};
                    if (got.payload_byte !== want.payload_byte)
                        diffs = {diffs, " payload_byte"};
                    if (got.byte_index !== want.byte_index)
                        diffs = {diffs, " byte_index"};
                    if (got.last !== want.last)
                        diffs = {diffs, " last"};
                    if (diffs != "")
                        report_mismatch($sformatf("result at index %0d:%s (got %h, want %h)",
                                                  want.byte_index, diffs, got, want));
                end
            end
            if (rx_ch.valid || res_ch.valid || due_results.size() != 0)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (byte_taken || res_taken)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // ------------------------------------------------------------------------
    // build the whole stimulus, run reset, wait for the end
    // ------------------------------------------------------------------------
    initial
    begin : run_ctl
        logic                  p_mode;
        logic [BYTE_W-1:0]     p_hdr;
        logic [CFG_DATA_W-1:0] p_max;
        logic [LEN_W-1:0]      lim7;
        int                    p_send;
        int                    p_recv;
        int                    start_bytes;
        bit                    timed_out;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_CHECKSUM_MODE;
        cfg_data      = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready  = 1'b1;
        timed_out     = 1'b0;

        // directed run at the reset settings (crc mode, header 0xaa, limit 32)
        push_entry(FEED_IDLING, CFG_CHECKSUM_MODE, '0, 0, 0);
        // empty payload, extreme field values, header value as function code
        assemble_frame(HEADER_RESET, MODE_RESET, 8'hFF, 8'h00, HEADER_RESET, 16'd0, 0,
                       CHK_INTACT);
        push_frame(frame_bytes.size());
        // one payload byte equal to the header, taken as data
        assemble_frame(HEADER_RESET, MODE_RESET, 8'h00, 8'hFF, 8'h55, 16'd1, 100,
                       CHK_INTACT);
        push_frame(frame_bytes.size());
        // one over the limit, then a high length byte
        assemble_frame(HEADER_RESET, MODE_RESET, 8'h12, 8'h34, 8'h56,
                       16'(MAXLEN_RESET) + 16'd1, 0, CHK_INTACT);
        push_frame(6);
        assemble_frame(HEADER_RESET, MODE_RESET, 8'h9A, 8'hBC, 8'hDE, 16'hFF00, 0,
                       CHK_INTACT);
        push_frame(6);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            phase_plan(p, p_mode, p_hdr, p_max, p_send, p_recv);
            push_entry(FEED_IDLING, CFG_CHECKSUM_MODE, '0, p_send, p_recv);
            push_entry(FEED_REG, CFG_CHECKSUM_MODE, BYTE_W'(p_mode), 0, 0);
            push_entry(FEED_REG, CFG_HEADER_BYTE, p_hdr, 0, 0);
            push_entry(FEED_REG, CFG_MAX_LENGTH, BYTE_W'(p_max), 0, 0);
            // a write past the register list must change nothing
            if (p == 0)
                push_entry(FEED_REG, CFG_UNUSED, 8'hFF, 0, 0);
            gen_mode = p_mode;
            gen_hdr  = p_hdr;
            lim7     = p_max[LEN_W-1:0];
            gen_lim  = (lim7 > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : int'(lim7);

            // finish the frame that was begun under the previous settings
            foreach (carry_bytes[i])
                push_entry(FEED_BYTE, CFG_CHECKSUM_MODE, carry_bytes[i], 0, 0);
            carry_bytes = {};

            start_bytes = fed_bytes;
            while (fed_bytes - start_bytes < PHASE_BYTES)
                add_random_sequence();

            // leave a frame open across the next register writes: its header
            // matched under this phase, its check is built for the next mode
            if (p == 2)
            begin
                phase_plan(3, p_mode, p_hdr, p_max, p_send, p_recv);
                lim7 = p_max[LEN_W-1:0];
                assemble_frame(gen_hdr, p_mode, random_byte(gen_hdr, 12),
                               random_byte(gen_hdr, 12), random_byte(gen_hdr, 12),
                               16'(pick_length((lim7 > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH
                                                                      : int'(lim7))),
                               12, CHK_INTACT);
                push_frame(3);
                for (int i = 3; i < frame_bytes.size(); i++)
                    carry_bytes.push_back(frame_bytes[i]);
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drain: all bytes in, all results out, then a quiet tail
        while (!timed_out && !(feed_q.size() == 0 && due_results.size() == 0 &&
                               quiet_cycles >= TAIL_CYCLES))
        begin
            @(negedge clk);
            if (stall_cycles >= STALL_LIMIT)
                timed_out = 1'b1;
        end
        if (timed_out)
            report_mismatch($sformatf("nothing moved for %0d cycles, %0d bytes unsent, %0d results due",
                                      STALL_LIMIT, feed_q.size(), due_results.size()));

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/frb_pkg.sv
rtl/frb_if.sv
rtl/frb_ram.sv
rtl/frb_dp.sv
rtl/frb_ctrl.sv
rtl/framed_byte_receiver.sv
dv/tb.sv
